// ===== rtl/efp_pkg.sv =====
package efp_pkg;

   // Frame format
   localparam int NUM_CHANNELS = 8;
   localparam int BODY_LEN     = 32;
   localparam int ADDR_W       = $clog2(BODY_LEN);
   localparam int STEP_W       = 6;

   localparam logic [7:0] SYNC_BYTE   = 8'hA0;
   localparam logic [7:0] TAIL_ACCEL  = 8'hC0;
   localparam logic [7:0] TAIL_ANALOG = 8'hC1;
   localparam logic [7:0] TAIL_MAX    = 8'hC6;

   localparam logic [ADDR_W-1:0] LAST_BODY_IDX = ADDR_W'(BODY_LEN - 1);

   // Emit sequencer steps
   localparam logic [STEP_W-1:0] STEP_SEQ        = 6'd0;
   localparam logic [STEP_W-1:0] STEP_CHAN_LAST  = 6'd24;
   localparam logic [STEP_W-1:0] STEP_TAIL       = 6'd25;
   localparam logic [STEP_W-1:0] STEP_AUX_FIRST  = 6'd26;
   localparam logic [STEP_W-1:0] STEP_AUX_LAST   = 6'd31;
   localparam logic [STEP_W-1:0] STEP_WORD_FIRST = 6'd32;
   localparam logic [STEP_W-1:0] STEP_WORD_LAST  = 6'd34;

   // Result slot codes
   localparam logic [4:0] SLOT_SEQ    = 5'd0;
   localparam logic [4:0] SLOT_TAIL   = 5'd9;
   localparam logic [4:0] SLOT_AUX    = 5'd10;
   localparam logic [4:0] SLOT_ACCEL  = 5'd16;
   localparam logic [4:0] SLOT_ANALOG = 5'd19;

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_EMIT
   } efp_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
      logic              capture_tail;
      logic              advance;
      logic              load;
      logic [STEP_W-1:0] step;
      logic              last;
   } efp_cmd_type;

   typedef struct packed {
      logic is_sync;
      logic tail_ok;
      logic has_words;
   } efp_status_type;

   // Does this step put a result out?
   function automatic logic step_emits(input logic [STEP_W-1:0] step,
                                       input logic has_words);
      logic hit;
      hit = (step == STEP_SEQ);
      for (int c = 1; c <= 8; c++) begin
         if (c <= NUM_CHANNELS && step == STEP_W'(3 * c)) hit = 1'b1;
      end
      if (step >= STEP_TAIL && step <= STEP_AUX_LAST) hit = 1'b1;
      if (has_words && step >= STEP_WORD_FIRST && step <= STEP_WORD_LAST) hit = 1'b1;
      return hit;
   endfunction

   // Slot code of the result a step puts out
   function automatic logic [4:0] step_slot(input logic [STEP_W-1:0] step,
                                            input logic is_accel);
      logic [4:0] slot;
      slot = SLOT_SEQ;
      for (int c = 1; c <= 8; c++) begin
         if (step == STEP_W'(3 * c)) slot = 5'(c);
      end
      if (step == STEP_TAIL) begin
         slot = SLOT_TAIL;
      end else if (step >= STEP_AUX_FIRST && step <= STEP_AUX_LAST) begin
         slot = SLOT_AUX + 5'(step - STEP_AUX_FIRST);
      end else if (step >= STEP_WORD_FIRST) begin
         slot = (is_accel ? SLOT_ACCEL : SLOT_ANALOG) + 5'(step - STEP_WORD_FIRST);
      end
      return slot;
   endfunction

   // Frame byte consumed at a step (the tail step reuses the previous byte)
   function automatic logic [ADDR_W-1:0] byte_of(input logic [STEP_W-1:0] step);
      logic [STEP_W-1:0] idx;
      idx = (step <= STEP_CHAN_LAST) ? step : step - STEP_W'(1);
      return idx[ADDR_W-1:0];
   endfunction

endpackage

// ===== rtl/efp_if.sv =====
interface efp_req_if import efp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface efp_rsp_if import efp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [4:0]         slot;
   logic signed [23:0] value;
   logic               last;

   modport source (output valid, output slot, output value, output last, input ready);
   modport sink   (input valid, input slot, input value, input last, output ready);
endinterface

// ===== rtl/efp_ctrl.sv =====
module efp_ctrl import efp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  efp_status_type status,
   output efp_cmd_type    cmd
);

   efp_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic              emit;
   logic              out_free;
   logic              advance;
   logic              final_step;
   logic              frame_done;
   logic [STEP_W-1:0] last_step;

   // Handshake and step qualifiers
   assign accept     = req_valid && req_ready;
   assign emit       = step_emits(step_ff, status.has_words);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = (state_ff == ST_EMIT) && (!emit || out_free);
   assign last_step  = status.has_words ? STEP_WORD_LAST : STEP_AUX_LAST;
   assign final_step = (step_ff == last_step);
   assign frame_done = (state_ff == ST_COLLECT) && accept && (count_ff == LAST_BODY_IDX);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.is_sync) state_in = ST_COLLECT;
         end
         ST_COLLECT: begin
            if (frame_done) state_in = status.tail_ok ? ST_EMIT : ST_HUNT;
         end
         ST_EMIT: begin
            if (advance && final_step) state_in = ST_HUNT;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   // Byte counter and step counter
   always_comb begin
      count_in = count_ff;
      if (state_ff != ST_COLLECT) count_in = '0;
      else if (accept) count_in = count_ff + ADDR_W'(1);

      step_in = step_ff;
      if (state_ff != ST_EMIT) step_in = '0;
      else if (advance) step_in = step_ff + STEP_W'(1);
   end

   // Outputs
   always_comb begin
      req_ready        = 1'b0;
      cmd.wr_en        = 1'b0;
      cmd.capture_tail = 1'b0;
      cmd.advance      = 1'b0;
      cmd.load         = 1'b0;
      unique case (state_ff)
         ST_HUNT: begin
            req_ready = 1'b1;
         end
         ST_COLLECT: begin
            req_ready        = 1'b1;
            cmd.wr_en        = accept;
            cmd.capture_tail = frame_done;
         end
         ST_EMIT: begin
            cmd.advance = advance;
            cmd.load    = advance && emit;
         end
         default: req_ready = 1'b0;
      endcase
      cmd.wr_addr = count_ff;
      cmd.rd_addr = byte_of(step_in);
      cmd.step    = step_ff;
      cmd.last    = final_step;
   end

   // Result valid: set on load, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A load never overwrites a beat that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   // Sequencer stays inside the run
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (step_ff <= STEP_WORD_LAST))
      else $error("emit step out of range");

   // The final step of a run returns to hunting
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && advance && final_step) |=> (state_ff == ST_HUNT))
      else $error("run did not end");

   // A new frame starts collecting at byte zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HUNT && accept && status.is_sync) |=> (count_ff == '0))
      else $error("frame did not start at byte zero");

endmodule

// ===== rtl/efp_dpath.sv =====
module efp_dpath import efp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_byte,
   input  efp_cmd_type        cmd,
   output efp_status_type     status,
   output logic [4:0]         rsp_slot,
   output logic signed [23:0] rsp_value,
   output logic               rsp_last
);

   logic [7:0]         frame_mem_ff [BODY_LEN];
   logic [7:0]         rd_data_ff;
   logic [7:0]         tail_ff;
   logic [15:0]        chan_ff, chan_in;
   logic [47:0]        aux_ff, aux_in;
   logic [15:0]        held_ff [3];
   logic [4:0]         slot_ff;
   logic signed [23:0] value_ff, value_in;
   logic               last_ff;

   logic               is_accel;
   logic [1:0]         word_idx;
   logic [15:0]        word;
   logic               chan_step;
   logic               aux_step;
   logic               held_upd;

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) frame_mem_ff[cmd.wr_addr] <= req_byte;
      rd_data_ff <= frame_mem_ff[cmd.rd_addr];
   end

   // Input byte decode and tail kind
   assign is_accel         = (tail_ff == TAIL_ACCEL);
   assign status.is_sync   = (req_byte == SYNC_BYTE);
   assign status.tail_ok   = (req_byte >= TAIL_ACCEL) && (req_byte <= TAIL_MAX);
   assign status.has_words = is_accel || (tail_ff == TAIL_ANALOG);

   // Byte assembly for channels and aux bytes
   assign chan_step = cmd.advance && (cmd.step <= STEP_CHAN_LAST);
   assign aux_step  = cmd.advance && (cmd.step >= STEP_AUX_FIRST)
                      && (cmd.step <= STEP_AUX_LAST);
   assign chan_in   = chan_step ? {chan_ff[7:0], rd_data_ff} : chan_ff;
   assign aux_in    = aux_step ? {aux_ff[39:0], rd_data_ff} : aux_ff;
   assign held_upd  = aux_step && (cmd.step == STEP_AUX_LAST) && is_accel
                      && (aux_in[47:32] != 16'd0);

   // Accel or analog word for the trailing steps
   assign word_idx = 2'(cmd.step - STEP_WORD_FIRST);
   always_comb begin
      case (word_idx)
         2'd0:    word = is_accel ? held_ff[0] : aux_ff[47:32];
         2'd1:    word = is_accel ? held_ff[1] : aux_ff[31:16];
         default: word = is_accel ? held_ff[2] : aux_ff[15:0];
      endcase
   end

   // Result value select
   always_comb begin
      if (cmd.step == STEP_TAIL) begin
         value_in = {16'd0, tail_ff};
      end else if (cmd.step == STEP_SEQ || (cmd.step >= STEP_AUX_FIRST
                   && cmd.step <= STEP_AUX_LAST)) begin
         value_in = {16'd0, rd_data_ff};
      end else if (cmd.step <= STEP_CHAN_LAST) begin
         value_in = {chan_ff, rd_data_ff};
      end else begin
         value_in = {{8{word[15]}}, word};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_tail) tail_ff <= req_byte;
      chan_ff <= chan_in;
      aux_ff  <= aux_in;
      if (cmd.load) begin
         slot_ff  <= step_slot(cmd.step, is_accel);
         value_ff <= value_in;
         last_ff  <= cmd.last;
      end
   end

   // Held accel words, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff[0] <= '0;
         held_ff[1] <= '0;
         held_ff[2] <= '0;
      end else if (held_upd) begin
         held_ff[0] <= aux_in[47:32];
         held_ff[1] <= aux_in[31:16];
         held_ff[2] <= aux_in[15:0];
      end
   end

   assign rsp_slot  = slot_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== rtl/eeg_frame_parser_top.sv =====
// EEG frame parser.
// req_ch carries one received serial byte per beat. The parser hunts for the
// start byte 0xA0, then stores the next 32 bytes. If the final byte is an end
// byte in 0xC0..0xC6, a run of results leaves on rsp_ch: sample number, eight
// channels, end byte, six aux bytes, then three accel words (0xC0) or three
// analog words (0xC1). last marks the final beat of a run. Bad frames vanish.
// Throughput: one byte per cycle while hunting or collecting. After a good
// frame the emit sequencer walks the frame store one byte per cycle, unless
// the receiver stalls, through its single read port, and req_ch.ready is low
// for the whole run. Once the end byte is taken the controller enters its emit
// state, where the first result is loaded into the output register.
// Result beats sit in an output register; a stall holds the register and
// pauses the sequencer without losing data.
// Reset (synchronous, active high) returns to hunting, clears the held accel
// words and drops any pending result. The frame store needs no clearing.
module eeg_frame_parser_top import efp_pkg::*; (
   input logic     clock,
   input logic     reset,
   efp_req_if.sink req_ch,
   efp_rsp_if.source rsp_ch
);

   efp_cmd_type    cmd;
   efp_status_type status;

   efp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   efp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_byte  (req_ch.byte_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_slot  (rsp_ch.slot),
      .rsp_value (rsp_ch.value),
      .rsp_last  (rsp_ch.last)
   );

endmodule
